[rtl/core/hrp_pkg.sv]
// ----------------------------------------------------------------------------
// hrp_pkg
// shared types, constants and character tables for the request header parser
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int DATA_W          = 8;
    localparam int LIMIT_W         = 16;
    localparam int POS_W           = 16;
    localparam int ACC_W           = 4;
    localparam int REM_OUT_W       = 32;
    localparam int LENGTH_BITS_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd8192;

    // output word layout
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 1;
    localparam int OFS_PHASE   = 0;
    localparam int OFS_BODY    = 2;
    localparam int OFS_KEEP    = 10;
    localparam int OFS_LEN     = 11;
    localparam int OFS_REM     = 12;
    localparam int OFS_UPLOAD  = 44;
    localparam int PAD_W       = 3;

    // phase codes as they appear on the output
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;
    localparam logic [1:0] PH_ERROR  = 2'd3;

    // match masks and counts
    localparam logic [ACC_W-1:0] MASK_BOTH = 4'd3;
    localparam logic [ACC_W-1:0] KEEP_LEN  = 4'd10;

    // character constants
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_CAP_C = "C";
    localparam logic [7:0] CH_PLUS  = "+";

    typedef enum logic [3:0] {
        S_HEADER = 4'b0001,
        S_BODY   = 4'b0010,
        S_DONE   = 4'b0100,
        S_ERROR  = 4'b1000
    } hrp_phase_t;

    typedef enum logic [4:0] {
        K_REQ      = 5'b00001,
        K_HDR      = 5'b00010,
        K_CLEN_WS  = 5'b00100,
        K_CLEN_DIG = 5'b01000,
        K_CONN_VAL = 5'b10000
    } hrp_kind_t;

    // one classified word as it travels from front to back
    typedef struct packed {
        logic        restart;
        logic [7:0]  raw;
        logic [7:0]  lower;
        logic        is_lf;
        logic        is_cr;
        logic        is_space;
        logic        is_digit;
        logic [3:0]  digit;
        logic        is_plus;
        logic        is_cap_c;
    } hrp_item_t;

    function automatic logic [1:0] phase_code(input hrp_phase_t ph);
        logic [1:0] code;
        code = PH_HEADER;
        unique case (ph)
            S_HEADER: code = PH_HEADER;
            S_BODY:   code = PH_BODY;
            S_DONE:   code = PH_DONE;
            S_ERROR:  code = PH_ERROR;
            default:  code = PH_HEADER;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (idx)
            2'd0: ch = "p";
            2'd1: ch = "o";
            2'd2: ch = "s";
            2'd3: ch = "t";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] put_char(input logic [1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (idx)
            2'd0: ch = "p";
            2'd1: ch = "u";
            2'd2: ch = "t";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (idx)
            4'd0:  ch = "c";
            4'd1:  ch = "o";
            4'd2:  ch = "n";
            4'd3:  ch = "t";
            4'd4:  ch = "e";
            4'd5:  ch = "n";
            4'd6:  ch = "t";
            4'd7:  ch = "-";
            4'd8:  ch = "l";
            4'd9:  ch = "e";
            4'd10: ch = "n";
            4'd11: ch = "g";
            4'd12: ch = "t";
            4'd13: ch = "h";
            4'd14: ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] conn_char(input logic [3:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (idx)
            4'd0:  ch = "c";
            4'd1:  ch = "o";
            4'd2:  ch = "n";
            4'd3:  ch = "n";
            4'd4:  ch = "e";
            4'd5:  ch = "c";
            4'd6:  ch = "t";
            4'd7:  ch = "i";
            4'd8:  ch = "o";
            4'd9:  ch = "n";
            4'd10: ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] keep_char(input logic [3:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (idx)
            4'd0: ch = "k";
            4'd1: ch = "e";
            4'd2: ch = "e";
            4'd3: ch = "p";
            4'd4: ch = "-";
            4'd5: ch = "a";
            4'd6: ch = "l";
            4'd7: ch = "i";
            4'd8: ch = "v";
            4'd9: ch = "e";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/core/http_request_header_parser.sv]
// ----------------------------------------------------------------------------
// http_request_header_parser
// byte-wise request header parser with content-length body pass-through
// ----------------------------------------------------------------------------
// Takes one request byte per word and returns one status word per byte. The
// sustained rate is one word per cycle in both directions while m_tready is
// held high; the status word for a byte passes the input register, the
// two-entry queue and the output register, and the whole per-byte parse step,
// including the multiply-by-ten length update, is combinational logic in front
// of the output register. tuser on the input restarts the parser; header_limit
// is written through cfg_we/cfg_wdata while the block is idle (the user is
// bound to this; the block has no check for it) and is kept over a restart.
module http_request_header_parser
#(
    parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hrp_pkg::LIMIT_W-1:0]       cfg_wdata,  // header_limit
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hrp_pkg::S_TDATA_W-1:0]     s_tdata,    // data_byte
    input  logic [hrp_pkg::S_TUSER_W-1:0]     s_tuser,    // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // phase, body_byte, keep_alive, length_known, bytes_remaining, has_body
    output logic [hrp_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [hrp_pkg::M_TUSER_W-1:0]     m_tuser     // body_valid
);

    logic [hrp_pkg::LIMIT_W-1:0] limit_reg;
    logic [hrp_pkg::LIMIT_W-1:0] limit_next;

    logic               fq_valid;
    logic               fq_ready;
    hrp_pkg::hrp_item_t fq_item;
    logic               qb_valid;
    logic               qb_ready;
    hrp_pkg::hrp_item_t qb_item;

    assign limit_next = cfg_we ? cfg_wdata : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= hrp_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    hrp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    hrp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    hrp_back
    #(
        .LENGTH_BITS (LENGTH_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .header_limit (limit_reg),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_item       (qb_item),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

[rtl/core/hrp_front.sv]
// ----------------------------------------------------------------------------
// hrp_front
// input stage: takes stream words and classifies each byte
// ----------------------------------------------------------------------------
module hrp_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [hrp_pkg::S_TDATA_W-1:0] s_tdata,   // data_byte
    input  logic [hrp_pkg::S_TUSER_W-1:0] s_tuser,   // command
    output logic                      q_valid,
    input  logic                      q_ready,
    output hrp_pkg::hrp_item_t        q_item
);

    logic               vld_reg;
    logic               vld_next;
    hrp_pkg::hrp_item_t item_reg;
    hrp_pkg::hrp_item_t item_next;
    logic               load;
    logic [7:0]         b;

    assign b        = s_tdata[7:0];
    assign s_tready = !vld_reg || q_ready;
    assign load     = s_tvalid && s_tready;
    assign vld_next = load || (vld_reg && !q_ready);

    always_comb
    begin
        item_next          = item_reg;
        item_next.restart  = s_tuser[0];
        item_next.raw      = b;
        item_next.lower    = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        item_next.is_lf    = (b == hrp_pkg::CH_LF);
        item_next.is_cr    = (b == hrp_pkg::CH_CR);
        item_next.is_space = (b == " ") || (b >= 8'd9 && b <= 8'd13);
        item_next.is_digit = (b >= "0" && b <= "9");
        item_next.digit    = 4'(b - "0");
        item_next.is_plus  = (b == hrp_pkg::CH_PLUS);
        item_next.is_cap_c = (b == hrp_pkg::CH_CAP_C);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign q_valid = vld_reg;
    assign q_item  = item_reg;

endmodule

[rtl/core/hrp_queue.sv]
// ----------------------------------------------------------------------------
// hrp_queue
// short queue of classified words between front and back
// ----------------------------------------------------------------------------
module hrp_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hrp_pkg::hrp_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output hrp_pkg::hrp_item_t out_item
);

    localparam int PTR_W = $clog2(hrp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hrp_pkg::QUEUE_DEPTH + 1);

    hrp_pkg::hrp_item_t     slot_reg [hrp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push;
    logic                   pop;

    assign in_ready  = (count_reg != CNT_W'(hrp_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/core/hrp_back.sv]
// ----------------------------------------------------------------------------
// hrp_back
// parser state: header matching, length capture, body count, output register
// ----------------------------------------------------------------------------
module hrp_back
#(
    parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [hrp_pkg::LIMIT_W-1:0]        header_limit,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  hrp_pkg::hrp_item_t                 q_item,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hrp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [hrp_pkg::M_TUSER_W-1:0]      m_tuser
);

    localparam int POS_W = hrp_pkg::POS_W;
    localparam int ACC_W = hrp_pkg::ACC_W;
    localparam int PROD_W = LENGTH_BITS + 4;

    hrp_pkg::hrp_phase_t      phase_reg, phase_next;
    hrp_pkg::hrp_kind_t       kind_reg, kind_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]         stored_reg, stored_next;
    logic                     pm_reg, pm_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]   rem_reg, rem_next;
    logic                     keep_reg, keep_next;
    logic                     len_reg, len_next;
    logic                     upload_reg, upload_next;
    logic                     cr_reg, cr_next;
    logic                     body_valid;

    logic                     out_vld_reg;
    logic [hrp_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [hrp_pkg::M_TUSER_W-1:0] out_user_reg;
    logic [hrp_pkg::M_TDATA_W-1:0] out_data_next;
    logic                     take;

    logic [7:0]               c;
    logic                     post_ok, put_ok, clen_ok, conn_ok, keep_ok;
    logic [1:0]               m_req, mh, m_hdr;
    logic                     hit_req, hit_clen, hit_conn;
    logic                     empty_line;
    logic [PROD_W-1:0]        rem_ext, prod;
    logic                     sat;
    logic [LENGTH_BITS-1:0]   rem_digit, rem_dec;
    logic [LENGTH_BITS+hrp_pkg::REM_OUT_W-1:0] rem_wide;

    assign take    = q_valid && (!out_vld_reg || m_tready);
    assign q_ready = !out_vld_reg || m_tready;
    assign c       = q_item.lower;

    // prefix comparisons at the current line position (keep-alive at the match count)
    assign post_ok = (pos_reg < POS_W'(4)) && (c == hrp_pkg::post_char(pos_reg[1:0]));
    assign put_ok  = (pos_reg < POS_W'(3)) && (c == hrp_pkg::put_char(pos_reg[1:0]));
    assign clen_ok = (pos_reg < POS_W'(15)) && (c == hrp_pkg::clen_char(pos_reg[3:0]));
    assign conn_ok = (pos_reg < POS_W'(11)) && (c == hrp_pkg::conn_char(pos_reg[3:0]));
    assign keep_ok = (acc_reg < hrp_pkg::KEEP_LEN) && (c == hrp_pkg::keep_char(acc_reg));

    assign m_req   = {acc_reg[1] & put_ok, acc_reg[0] & post_ok};
    assign hit_req = (m_req[0] && pos_reg == POS_W'(3)) || (m_req[1] && pos_reg == POS_W'(2));

    assign mh       = (pos_reg == '0 && !q_item.is_cap_c) ? 2'b00 : acc_reg[1:0];
    assign m_hdr    = {mh[1] & conn_ok, mh[0] & clen_ok};
    assign hit_clen = m_hdr[0] && (pos_reg == POS_W'(14));
    assign hit_conn = m_hdr[1] && (pos_reg == POS_W'(10));

    assign empty_line = (pos_reg == (cr_reg ? POS_W'(1) : POS_W'(0)));

    // decimal accumulate with saturation: 10 * rem + digit
    assign rem_ext   = {4'b0000, rem_reg};
    assign prod      = (rem_ext << 3) + (rem_ext << 1)
                       + {{LENGTH_BITS{1'b0}}, q_item.digit};
    assign sat       = |prod[PROD_W-1:LENGTH_BITS];
    assign rem_digit = sat ? '1 : prod[LENGTH_BITS-1:0];
    assign rem_dec   = (rem_reg != '0) ? rem_reg - LENGTH_BITS'(1) : rem_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        pos_next    = pos_reg;
        stored_next = stored_reg;
        pm_next     = pm_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        keep_next   = keep_reg;
        len_next    = len_reg;
        upload_next = upload_reg;
        cr_next     = cr_reg;
        body_valid  = 1'b0;

        if (q_item.restart)
        begin
            phase_next  = hrp_pkg::S_HEADER;
            kind_next   = hrp_pkg::K_REQ;
            pos_next    = '0;
            stored_next = '0;
            pm_next     = 1'b1;
            acc_next    = hrp_pkg::MASK_BOTH;
            rem_next    = '0;
            keep_next   = 1'b0;
            len_next    = 1'b0;
            upload_next = 1'b0;
            cr_next     = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                hrp_pkg::S_HEADER:
                begin
                    priority if (stored_reg >= header_limit)
                    begin
                        phase_next = hrp_pkg::S_ERROR;
                    end
                    else if (q_item.is_lf)
                    begin
                        if (cr_reg)
                        begin
                            stored_next = stored_reg - POS_W'(1);
                        end
                        if (empty_line)
                        begin
                            phase_next = (upload_reg && len_reg && rem_reg != '0)
                                         ? hrp_pkg::S_BODY : hrp_pkg::S_DONE;
                        end
                        pos_next  = '0;
                        kind_next = hrp_pkg::K_HDR;
                        pm_next   = 1'b1;
                        acc_next  = hrp_pkg::MASK_BOTH;
                        cr_next   = 1'b0;
                    end
                    else
                    begin
                        if (pm_reg)
                        begin
                            unique case (kind_reg)
                                hrp_pkg::K_REQ:
                                begin
                                    if (hit_req)
                                    begin
                                        upload_next = 1'b1;
                                        pm_next     = 1'b0;
                                    end
                                    else
                                    begin
                                        acc_next = {2'b00, m_req};
                                        pm_next  = (m_req != 2'b00);
                                    end
                                end
                                hrp_pkg::K_HDR:
                                begin
                                    priority if (hit_clen)
                                    begin
                                        kind_next = hrp_pkg::K_CLEN_WS;
                                        len_next  = 1'b1;
                                        rem_next  = '0;
                                    end
                                    else if (hit_conn)
                                    begin
                                        kind_next = hrp_pkg::K_CONN_VAL;
                                        acc_next  = '0;
                                    end
                                    else
                                    begin
                                        acc_next = {2'b00, m_hdr};
                                        pm_next  = (m_hdr != 2'b00);
                                    end
                                end
                                hrp_pkg::K_CLEN_WS:
                                begin
                                    priority if (q_item.is_space)
                                    begin
                                        pm_next = 1'b1;
                                    end
                                    else if (q_item.is_plus)
                                    begin
                                        kind_next = hrp_pkg::K_CLEN_DIG;
                                    end
                                    else if (q_item.is_digit)
                                    begin
                                        kind_next = hrp_pkg::K_CLEN_DIG;
                                        rem_next  = rem_digit;
                                    end
                                    else
                                    begin
                                        pm_next = 1'b0;
                                    end
                                end
                                hrp_pkg::K_CLEN_DIG:
                                begin
                                    if (q_item.is_digit)
                                    begin
                                        rem_next = rem_digit;
                                    end
                                    else
                                    begin
                                        pm_next = 1'b0;
                                    end
                                end
                                default:
                                begin
                                    priority if (acc_reg == '0 && q_item.is_space)
                                    begin
                                        pm_next = 1'b1;
                                    end
                                    else if (keep_ok)
                                    begin
                                        acc_next = acc_reg + ACC_W'(1);
                                        if (acc_reg == hrp_pkg::KEEP_LEN - ACC_W'(1))
                                        begin
                                            keep_next = 1'b1;
                                            pm_next   = 1'b0;
                                        end
                                    end
                                    else
                                    begin
                                        pm_next = 1'b0;
                                    end
                                end
                            endcase
                        end
                        if (pos_reg != '1)
                        begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                        if (stored_reg != '1)
                        begin
                            stored_next = stored_reg + POS_W'(1);
                        end
                        cr_next = q_item.is_cr;
                    end
                end
                hrp_pkg::S_BODY:
                begin
                    body_valid = 1'b1;
                    rem_next   = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = hrp_pkg::S_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    assign rem_wide = {{hrp_pkg::REM_OUT_W{1'b0}}, rem_next};

    always_comb
    begin
        out_data_next = '0;
        out_data_next[hrp_pkg::OFS_PHASE +: 2]  = hrp_pkg::phase_code(phase_next);
        out_data_next[hrp_pkg::OFS_BODY +: 8]   = body_valid ? q_item.raw : 8'h00;
        out_data_next[hrp_pkg::OFS_KEEP]        = keep_next;
        out_data_next[hrp_pkg::OFS_LEN]         = len_next;
        out_data_next[hrp_pkg::OFS_REM +: hrp_pkg::REM_OUT_W] =
            rem_wide[hrp_pkg::REM_OUT_W-1:0];
        out_data_next[hrp_pkg::OFS_UPLOAD]      = upload_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hrp_pkg::S_HEADER;
            kind_reg    <= hrp_pkg::K_REQ;
            pos_reg     <= '0;
            stored_reg  <= '0;
            pm_reg      <= 1'b1;
            acc_reg     <= hrp_pkg::MASK_BOTH;
            rem_reg     <= '0;
            keep_reg    <= 1'b0;
            len_reg     <= 1'b0;
            upload_reg  <= 1'b0;
            cr_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                pos_reg    <= pos_next;
                stored_reg <= stored_next;
                pm_reg     <= pm_next;
                acc_reg    <= acc_next;
                rem_reg    <= rem_next;
                keep_reg   <= keep_next;
                len_reg    <= len_next;
                upload_reg <= upload_next;
                cr_reg     <= cr_next;
            end
            if (take)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= body_valid;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[rtl/core/hrp_checker.sv]
// ----------------------------------------------------------------------------
// hrp_checker
// port-level checks on the parser output stream
// ----------------------------------------------------------------------------
module hrp_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [hrp_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [hrp_pkg::M_TUSER_W-1:0] m_tuser
);

    logic [1:0] ph;

    assign ph = m_tdata[hrp_pkg::OFS_PHASE +: 2];

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // a body byte is only flagged in body or on the last body byte
    a_body_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (ph == hrp_pkg::PH_BODY || ph == hrp_pkg::PH_DONE))
        else $error("body byte outside body phase");

    // non-body words carry a zero byte
    a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[hrp_pkg::OFS_BODY +: 8] == 8'h00)
        else $error("body byte not cleared");

    // body phase needs an upload method with a known length
    a_body_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ph == hrp_pkg::PH_BODY |->
            m_tdata[hrp_pkg::OFS_UPLOAD] && m_tdata[hrp_pkg::OFS_LEN])
        else $error("body phase without length");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level bench for the byte-wise request header parser
// ----------------------------------------------------------------------------
// Request bytes go in on the slave side in bursts with random gaps, the
// status words come back on the master side under a changing stall pattern.
// A parser model inside the bench follows every accepted byte and each
// status word is compared field by field against it. Directed requests hit
// the method, length, keep-alive and size-limit corner cases; the random
// part sends mostly well-formed requests with random content, some broken
// ones and plain noise, with the header limit changed between requests.
// ----------------------------------------------------------------------------
module tb_top;

    localparam longint unsigned LEN_MAX =
        64'hFFFF_FFFF_FFFF_FFFF >> (64 - hrp_pkg::LENGTH_BITS_DEF);

    typedef struct packed {
        logic [1:0]  phase;
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        conn_persist;
        logic        length_known;
        logic [31:0] bytes_remaining;
        logic        has_body;
    } status_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [hrp_pkg::LIMIT_W-1:0]   cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [hrp_pkg::S_TDATA_W-1:0] s_tdata = '0;   // data_byte
    logic [hrp_pkg::S_TUSER_W-1:0] s_tuser = '0;   // command
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // phase, body_byte, keep_alive, length_known, bytes_remaining, has_body
    logic [hrp_pkg::M_TDATA_W-1:0] m_tdata;
    logic [hrp_pkg::M_TUSER_W-1:0] m_tuser;        // body_valid

    http_request_header_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser model state
    logic [1:0]          hdr_phase;
    int unsigned         line_pos;
    int unsigned         hdr_bytes;
    hrp_pkg::hrp_kind_t  line_kind;
    bit                  still_matching;
    int unsigned         match_acc;
    longint unsigned     body_left;
    bit                  seen_persist;
    bit                  seen_length;
    bit                  seen_upload;
    bit                  last_was_cr;
    int unsigned         limit_shadow;

    status_t pending_status[$];
    status_t got_want;

    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int limits_written = 0;
    int requests_sent = 0;
    int burst_left = 0;

    int rx_mode = 0;
    int rx_left = 0;
    int rx_hold = 0;

    function automatic bit is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic longint unsigned push_digit(input longint unsigned v,
                                                   input int unsigned d);
        if (v > (LEN_MAX - d) / 10)
            return LEN_MAX;
        return v * 10 + d;
    endfunction

    // advance the match of two words by one character; bit 0 word a, bit 1 word b
    function automatic int unsigned match_pair(input int unsigned mask, input string a,
                                               input string b, input int unsigned pos,
                                               input int unsigned c,
                                               output int unsigned hit);
        hit = 0;
        if (mask[0])
        begin
            if (pos < a.len() && c == a[pos])
            begin
                if (pos == a.len() - 1)
                    hit = 1;
            end
            else
                mask[0] = 1'b0;
        end
        if (mask[1])
        begin
            if (pos < b.len() && c == b[pos])
            begin
                if (pos == b.len() - 1)
                    hit = 2;
            end
            else
                mask[1] = 1'b0;
        end
        return mask;
    endfunction

    task automatic clear_parser();
        hdr_phase      = hrp_pkg::PH_HEADER;
        line_pos       = 0;
        hdr_bytes      = 0;
        line_kind      = hrp_pkg::K_REQ;
        still_matching = 1'b1;
        match_acc      = 3;
        body_left      = 0;
        seen_persist   = 1'b0;
        seen_length    = 1'b0;
        seen_upload    = 1'b0;
        last_was_cr    = 1'b0;
    endtask

    task automatic predict_status(input bit cmd, input logic [7:0] b, output status_t st);
        int unsigned c;
        int unsigned hit;
        int unsigned m;
        int unsigned len;
        bit          valid;
        string       keep_word;
        keep_word = "keep-alive";
        valid = 1'b0;
        c = (b >= "A" && b <= "Z") ? b + 32 : b;
        if (cmd)
            clear_parser();
        else if (hdr_phase == hrp_pkg::PH_HEADER)
        begin
            if (hdr_bytes + 1 > limit_shadow)
                hdr_phase = hrp_pkg::PH_ERROR;
            else if (b == hrp_pkg::CH_LF)
            begin
                len = line_pos;
                if (last_was_cr)
                begin
                    len--;
                    hdr_bytes--;
                end
                if (len == 0)
                    hdr_phase = (seen_upload && seen_length && body_left != 0)
                                ? hrp_pkg::PH_BODY : hrp_pkg::PH_DONE;
                line_pos       = 0;
                line_kind      = hrp_pkg::K_HDR;
                still_matching = 1'b1;
                match_acc      = 3;
                last_was_cr    = 1'b0;
            end
            else
            begin
                if (still_matching)
                begin
                    case (line_kind)
                        hrp_pkg::K_REQ:
                        begin
                            m = match_pair(match_acc, "post", "put", line_pos, c, hit);
                            if (hit != 0)
                            begin
                                seen_upload    = 1'b1;
                                still_matching = 1'b0;
                            end
                            else
                            begin
                                match_acc = m;
                                if (m == 0)
                                    still_matching = 1'b0;
                            end
                        end
                        hrp_pkg::K_HDR:
                        begin
                            m = match_acc;
                            if (line_pos == 0 && b != hrp_pkg::CH_CAP_C)
                                m = 0;
                            m = match_pair(m, "content-length:", "connection:", line_pos,
                                           c, hit);
                            if (hit == 1)
                            begin
                                line_kind   = hrp_pkg::K_CLEN_WS;
                                seen_length = 1'b1;
                                body_left   = 0;
                            end
                            else if (hit == 2)
                            begin
                                line_kind = hrp_pkg::K_CONN_VAL;
                                match_acc = 0;
                            end
                            else
                            begin
                                match_acc = m;
                                if (m == 0)
                                    still_matching = 1'b0;
                            end
                        end
                        hrp_pkg::K_CLEN_WS:
                        begin
                            if (is_space(b))
                                ;
                            else if (b == hrp_pkg::CH_PLUS)
                                line_kind = hrp_pkg::K_CLEN_DIG;
                            else if (b >= "0" && b <= "9")
                            begin
                                line_kind = hrp_pkg::K_CLEN_DIG;
                                body_left = push_digit(body_left, b - "0");
                            end
                            else
                                still_matching = 1'b0;
                        end
                        hrp_pkg::K_CLEN_DIG:
                        begin
                            if (b >= "0" && b <= "9")
                                body_left = push_digit(body_left, b - "0");
                            else
                                still_matching = 1'b0;
                        end
                        default:
                        begin
                            if (match_acc == 0 && is_space(b))
                                ;
                            else if (match_acc < 10 && c == keep_word[match_acc])
                            begin
                                match_acc++;
                                if (match_acc == 10)
                                begin
                                    seen_persist   = 1'b1;
                                    still_matching = 1'b0;
                                end
                            end
                            else
                                still_matching = 1'b0;
                        end
                    endcase
                end
                if (line_pos < 16'hFFFF)
                    line_pos++;
                if (hdr_bytes < 16'hFFFF)
                    hdr_bytes++;
                last_was_cr = (b == hrp_pkg::CH_CR);
            end
        end
        else if (hdr_phase == hrp_pkg::PH_BODY)
        begin
            valid = 1'b1;
            if (body_left != 0)
                body_left--;
            if (body_left == 0)
                hdr_phase = hrp_pkg::PH_DONE;
        end
        st.phase           = hdr_phase;
        st.body_valid      = valid;
        st.body_byte       = valid ? b : 8'h00;
        st.conn_persist    = seen_persist;
        st.length_known    = seen_length;
        st.bytes_remaining = body_left[31:0];
        st.has_body        = seen_upload;
    endtask

    task automatic send_word(input bit cmd, input logic [7:0] b);
        int gap;
        status_t st;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predict_status(cmd, b, st);
        pending_status.insert(pending_status.size(), st);
        words_sent++;
    endtask

    task automatic restart_parser();
        send_word(1'b1, 8'($urandom_range(0, 255)));
        requests_sent++;
    endtask

    task automatic send_text(input string s, input bit mix);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if (mix && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))
                && $urandom_range(0, 1))
                ch = ch ^ 8'h20;
            send_word(1'b0, ch);
        end
    endtask

    // 0 bare lf, 1 cr lf, 2 stray cr then cr lf
    task automatic end_line(input int ending);
        if (ending == 2)
            send_word(1'b0, hrp_pkg::CH_CR);
        if (ending != 0)
            send_word(1'b0, hrp_pkg::CH_CR);
        send_word(1'b0, hrp_pkg::CH_LF);
    endtask

    task automatic send_line(input string s, input int ending);
        send_text(s, 1'b0);
        end_line(ending);
    endtask

    task automatic send_random_bytes(input int n, input bit allow_lf);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            if (!allow_lf && b == hrp_pkg::CH_LF)
                b = 8'h00;
            send_word(1'b0, b);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic set_header_limit(input int unsigned v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v[hrp_pkg::LIMIT_W-1:0];
        limit_shadow = v;
        limits_written++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_request_without_body();
        restart_parser();
        send_line("GET / HTTP/1.1", 1);
        send_line("Host: x", 0);
        send_line("Content-Length: 4", 1);
        send_line("", 1);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
    endtask

    task automatic test_upload_with_length();
        restart_parser();
        send_line("post /up", 0);
        send_line("Content-Length:\t+3", 1);
        send_line("Connection:  Keep-Alive", 1);
        send_line("", 1);
        send_random_bytes(4, 1'b1);
    endtask

    task automatic test_length_sign_and_case();
        restart_parser();
        send_line("PuT /", 0);
        send_line("content-length: 9", 0);
        send_line("Content-Length: -7", 0);
        send_line("", 0);
        send_word(1'b0, 8'h55);
    endtask

    task automatic test_empty_first_line();
        restart_parser();
        send_line("", 1);
        send_word(1'b0, 8'hAA);
    endtask

    task automatic test_length_saturation();
        restart_parser();
        send_line("POST", 0);
        send_line("Content-Length: 99999999999", 0);
        send_line("", 0);
        send_random_bytes(3, 1'b1);
        restart_parser();
        send_line("PUT", 1);
        send_line("Content-Length: 7", 1);
        send_line("Content-Length: 2", 1);
        send_line("", 0);
        send_random_bytes(3, 1'b1);
    endtask

    task automatic test_header_limit();
        set_header_limit(1);
        restart_parser();
        send_text("GET", 1'b0);
        set_header_limit(6);
        // the cr before lf still counts at the size check of that lf
        restart_parser();
        send_line("GET", 1);
        send_line("ab", 1);
        send_word(1'b0, 8'h41);
        set_header_limit(65535);
        restart_parser();
        send_line("PUT /", 1);
        send_line("Content-Length: 1", 1);
        send_line("", 1);
        send_random_bytes(2, 1'b1);
        set_header_limit(hrp_pkg::LIMIT_RESET);
    endtask

    task automatic send_random_request();
        string word;
        string value;
        int unsigned n;
        int unsigned pick;
        restart_parser();
        if ($urandom_range(0, 11) == 0)
        begin
            send_random_bytes($urandom_range(1, 10), 1'b1);
            return;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: word = "POST";
            4, 5, 6:    word = "PUT";
            7:          word = "GET";
            8:          word = "PO";
            default:    word = "";
        endcase
        send_text(word, 1'b1);
        if (word.len() != 0 && $urandom_range(0, 1))
            send_text(" /x", 1'b0);
        end_line($urandom_range(0, 2));
        repeat ($urandom_range(0, 3))
        begin
            pick = $urandom_range(0, 6);
            if (pick <= 2)
            begin
                send_text("Content-Length:", $urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0: value = "";
                    1: value = " ";
                    default: value = "\t ";
                endcase
                case ($urandom_range(0, 7))
                    0: value = {value, "+"};
                    1: value = {value, "-"};
                    default: ;
                endcase
                if ($urandom_range(0, 7) == 0)
                    value = {value, $sformatf("%0d%0d", $urandom, $urandom)};
                else
                    value = {value, $sformatf("%0d", $urandom_range(0, 12))};
                if ($urandom_range(0, 5) == 0)
                    value = {value, "x9"};
                send_text(value, 1'b0);
            end
            else if (pick <= 4)
            begin
                send_text("Connection:", $urandom_range(0, 3) == 0);
                case ($urandom_range(0, 4))
                    0: send_text(" keep-alive", 1'b1);
                    1: send_text("\tkeep-alive, x", 1'b1);
                    2: send_text(" close", 1'b0);
                    3: send_text(" keep-al", 1'b0);
                    default: send_text("x keep-alive", 1'b0);
                endcase
            end
            else if (pick == 5)
                send_text("Content-Type: t", 1'b1);
            else
                send_random_bytes($urandom_range(0, 6), 1'b0);
            end_line($urandom_range(0, 2));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            send_random_bytes($urandom_range(0, 4), 1'b1);
            return;
        end
        end_line($urandom_range(0, 1));
        if (hdr_phase == hrp_pkg::PH_BODY)
        begin
            n = (body_left > 16) ? $urandom_range(1, 6) : int'(body_left);
            send_random_bytes(n, 1'b1);
        end
        send_random_bytes($urandom_range(0, 2), 1'b1);
    endtask

    task automatic test_random_requests();
        int start;
        int pick;
        start = words_sent;
        while (words_sent < start + 100)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(0, 5);
                if (pick == 0)
                    set_header_limit(1);
                else if (pick == 1)
                    set_header_limit(65535);
                else if (pick <= 3)
                    set_header_limit($urandom_range(8, 80));
                else
                    set_header_limit(hrp_pkg::LIMIT_RESET);
            end
            send_random_request();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 150);
        end
        else
            rx_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 2) != 0);
            default:
            begin
                if (rx_hold == 0)
                    rx_hold = $urandom_range(2, 18);
                rx_hold--;
                m_tready <= (rx_hold < 3);
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: unexpected status word %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                got_want = pending_status.pop_front();
                check_field("phase", got_want.phase, m_tdata[hrp_pkg::OFS_PHASE +: 2]);
                check_field("body_valid", got_want.body_valid, m_tuser[0]);
                check_field("body_byte", got_want.body_byte,
                            m_tdata[hrp_pkg::OFS_BODY +: 8]);
                check_field("persist", got_want.conn_persist, m_tdata[hrp_pkg::OFS_KEEP]);
                check_field("length_known", got_want.length_known,
                            m_tdata[hrp_pkg::OFS_LEN]);
                check_field("bytes_remaining", got_want.bytes_remaining,
                            m_tdata[hrp_pkg::OFS_REM +: 32]);
                check_field("has_body", got_want.has_body, m_tdata[hrp_pkg::OFS_UPLOAD]);
                check_field("padding", 32'd0,
                            m_tdata[hrp_pkg::M_TDATA_W-1 -: hrp_pkg::PAD_W]);
                words_checked++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        limit_shadow = hrp_pkg::LIMIT_RESET;
        clear_parser();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_request_without_body();
        test_upload_with_length();
        test_length_sign_and_case();
        test_empty_first_line();
        test_length_saturation();
        test_header_limit();
        test_random_requests();

        wait_drained();
        repeat (10) @(posedge clk);
        $display("covered %0d requests in %0d words, %0d header limit settings",
                 requests_sent, words_sent, limits_written);
        $display("checked %0d status words, %0d mismatches", words_checked, errors);
        if (errors == 0 && pending_status.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/core/hrp_pkg.sv
rtl/core/hrp_front.sv
rtl/core/hrp_queue.sv
rtl/core/hrp_back.sv
rtl/core/http_request_header_parser.sv
rtl/core/hrp_checker.sv
bench/tb_top.sv
